// ===== rtl/sned_pkg.sv =====
package sned_pkg;

    // Node table depth; node ids at or above it are dropped
    localparam int NODES   = 32;
    localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int MAX_EV  = 3;
    localparam int DEG_SCALE = 10;   // tenths of a degree per degree

    // Configuration register indexes
    localparam logic [2:0] CFG_LOW_BATT  = 3'd0;
    localparam logic [2:0] CFG_FLAT_LVL  = 3'd1;
    localparam logic [2:0] CFG_MIN_SPEED = 3'd2;
    localparam logic [2:0] CFG_BAND_RED  = 3'd3;
    localparam logic [2:0] CFG_BAND_YEL  = 3'd4;
    localparam logic [2:0] CFG_OVERLOAD  = 3'd5;
    localparam logic [2:0] CFG_LOAD_DLT  = 3'd6;

    // Node types
    localparam logic [2:0] TYPE_BEARING   = 3'd0;
    localparam logic [2:0] TYPE_LOAD      = 3'd1;
    localparam logic [2:0] TYPE_DOOR      = 3'd2;
    localparam logic [2:0] TYPE_TANK      = 3'd3;
    localparam logic [2:0] TYPE_HANDBRAKE = 3'd4;

    // Event codes
    localparam logic [3:0] EV_LOW_BATT  = 4'd0;
    localparam logic [3:0] EV_FLAT      = 4'd1;
    localparam logic [3:0] EV_BAND      = 4'd2;
    localparam logic [3:0] EV_OVERLOAD  = 4'd3;
    localparam logic [3:0] EV_LOAD_CHG  = 4'd4;
    localparam logic [3:0] EV_DOOR_OPEN = 4'd5;
    localparam logic [3:0] EV_DOOR_CLS  = 4'd6;
    localparam logic [3:0] EV_TANK_HOT  = 4'd7;
    localparam logic [3:0] EV_HB_APPL   = 4'd8;
    localparam logic [3:0] EV_HB_REL    = 4'd9;

    // Band codes
    localparam logic [1:0] BAND_GREEN  = 2'd1;
    localparam logic [1:0] BAND_YELLOW = 2'd2;
    localparam logic [1:0] BAND_RED    = 2'd3;

    typedef struct packed {
        logic        known;
        logic        door_is_open;
        logic        brake_on;
        logic [15:0] load;
        logic [1:0]  band;
        logic        batt_low;
        logic        tank_alarm;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  battery_pct;
        logic [15:0] reading;
        logic [15:0] vibration_index;
        logic        door_open_flag;
        logic        alarm_flag;
        logic        impact_flag;
        logic [8:0]  speed;
        logic        moving;
    } t_item;

    // Band limits are kept already scaled to tenths of a degree
    typedef struct packed {
        logic [6:0]  low_battery_pct;
        logic [14:0] flat_wheel_level;
        logic [8:0]  min_speed_kmh;
        logic [17:0] red_lim;
        logic [17:0] yel_lim;
        logic [15:0] overload_level;
        logic [15:0] load_step_min;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  code;
        logic        clr;
        logic [15:0] measured;
        logic [1:0]  from_state;
        logic [1:0]  to_state;
    } t_event;

    typedef struct packed {
        logic [1:0]               count;
        t_event [MAX_EV-1:0]      ev;
    } t_eval_res;

endpackage

// ===== rtl/sned_ram.sv =====
module sned_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic                              i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sned_eval.sv =====
module sned_eval (
    input  sned_pkg::t_item     i_item,
    input  sned_pkg::t_entry    i_ent,
    input  sned_pkg::t_cfg      i_cfg,
    output sned_pkg::t_eval_res o_res,
    output sned_pkg::t_entry    o_ent
);

    localparam int DEG_SCALE_M1 = sned_pkg::DEG_SCALE - 1;

    sned_pkg::t_event e0, ea, eb;
    logic             v0, va, vb;
    logic             low, hot, ap, flat;
    logic signed [17:0] rd_adj;
    logic [1:0]       band;
    logic signed [16:0] diff;
    logic [16:0]      diff_abs;

    // trunc(r/10) >= T  <=>  r + (r < 0 ? 9 : 0) >= 10*T
    always_comb begin
        rd_adj = 18'(signed'(i_item.reading));
        if (i_item.reading[15]) begin
            rd_adj = rd_adj + 18'(DEG_SCALE_M1);
        end
        if (rd_adj >= signed'(i_cfg.red_lim)) begin
            band = sned_pkg::BAND_RED;
        end else if (rd_adj >= signed'(i_cfg.yel_lim)) begin
            band = sned_pkg::BAND_YELLOW;
        end else begin
            band = sned_pkg::BAND_GREEN;
        end
    end

    assign diff     = 17'(signed'(i_item.reading)) - 17'(signed'(i_ent.load));
    assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
    assign low      = i_item.battery_pct <= i_cfg.low_battery_pct;
    assign hot      = i_item.alarm_flag && !i_item.impact_flag;
    assign ap       = i_item.reading != 16'd0;
    assign flat     = (i_item.speed > i_cfg.min_speed_kmh)
                   && (signed'(i_item.vibration_index)
                       >= signed'({1'b0, i_cfg.flat_wheel_level}));

    always_comb begin
        e0 = '0;
        ea = '0;
        eb = '0;
        v0 = 1'b0;
        va = 1'b0;
        vb = 1'b0;
        o_ent = i_ent;
        o_ent.known = 1'b1;
        o_ent.batt_low = low;

        e0.code = sned_pkg::EV_LOW_BATT;
        e0.measured = {9'd0, i_item.battery_pct};
        if (low && (!i_ent.known || !i_ent.batt_low)) begin
            v0 = 1'b1;
        end else if (!low && i_ent.known && i_ent.batt_low) begin
            v0 = 1'b1;
            e0.clr = 1'b1;
        end

        ea.measured = i_item.reading;
        eb.measured = i_item.reading;

        case (i_item.kind)
            sned_pkg::TYPE_BEARING: begin
                va = flat;
                ea.code = sned_pkg::EV_FLAT;
                ea.measured = i_item.vibration_index;
                vb = i_ent.known && (band != i_ent.band);
                eb.code = sned_pkg::EV_BAND;
                eb.from_state = i_ent.band;
                eb.to_state = band;
                o_ent.band = band;
            end
            sned_pkg::TYPE_LOAD: begin
                va = signed'(i_item.reading) >= signed'(i_cfg.overload_level);
                ea.code = sned_pkg::EV_OVERLOAD;
                vb = i_ent.known && (diff_abs >= {1'b0, i_cfg.load_step_min});
                eb.code = sned_pkg::EV_LOAD_CHG;
                o_ent.load = i_item.reading;
            end
            sned_pkg::TYPE_DOOR: begin
                va = i_ent.known && (i_item.door_open_flag != i_ent.door_is_open)
                  && !i_item.moving;
                ea.code = i_item.door_open_flag ? sned_pkg::EV_DOOR_OPEN
                                                : sned_pkg::EV_DOOR_CLS;
                ea.from_state = {1'b0, i_ent.door_is_open};
                ea.to_state = {1'b0, i_item.door_open_flag};
                o_ent.door_is_open = i_item.door_open_flag;
            end
            sned_pkg::TYPE_TANK: begin
                ea.code = sned_pkg::EV_TANK_HOT;
                if (hot && (!i_ent.known || !i_ent.tank_alarm)) begin
                    va = 1'b1;
                end else if (!hot && i_ent.known && i_ent.tank_alarm) begin
                    va = 1'b1;
                    ea.clr = 1'b1;
                end
                o_ent.tank_alarm = hot;
            end
            sned_pkg::TYPE_HANDBRAKE: begin
                va = i_ent.known && (ap != i_ent.brake_on) && !i_item.moving;
                ea.code = ap ? sned_pkg::EV_HB_APPL : sned_pkg::EV_HB_REL;
                ea.from_state = {1'b0, i_ent.brake_on};
                ea.to_state = {1'b0, ap};
                o_ent.brake_on = ap;
            end
            default: begin
            end
        endcase
    end

    // Pack the valid events to the low slots, in order
    always_comb begin
        o_res.count = 2'(v0) + 2'(va) + 2'(vb);
        o_res.ev[0] = v0 ? e0 : (va ? ea : eb);
        o_res.ev[1] = v0 ? (va ? ea : eb) : eb;
        o_res.ev[2] = eb;
    end

endmodule

// ===== rtl/sensor_node_edge_event_detector.sv =====
// Channel  | Ports                                             | Handshake
// ---------+---------------------------------------------------+--------------------------
// report   | i_node_id .. i_moving                             | taken when start && !busy
// event    | o_event_code .. o_last                            | o_event_valid, one cycle
// config   | i_cfg_we, i_cfg_idx, i_cfg_data                   | written when i_cfg_we
//
// A report with n events (0 to 3) first reads the node entry from the table RAM,
// then evaluates it and writes it back in ST_EVAL, then puts out one event per
// cycle. busy stays high until the last event is out, so the write-back always
// lands before the next read. Ids beyond the table are taken and dropped.
// Reset (synchronous, active low) marks every table entry as cleared through
// per-entry valid bits; there is no clearing pass. Events cannot be stalled.
module sensor_node_edge_event_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_node_id,
    input  logic [2:0]  i_node_type,
    input  logic [6:0]  i_battery_pct,
    input  logic signed [15:0] i_reading,
    input  logic signed [15:0] i_vibration_index,
    input  logic        i_door_open_flag,
    input  logic        i_alarm_flag,
    input  logic        i_impact_flag,
    input  logic [8:0]  i_speed_kmh,
    input  logic        i_moving,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_event_valid,
    output logic [3:0]  o_event_code,
    output logic        o_edge_res,
    output logic [4:0]  o_event_node,
    output logic signed [15:0] o_measured,
    output logic [1:0]  o_from_state,
    output logic [1:0]  o_to_state,
    output logic        o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int ENT_W = $bits(sned_pkg::t_entry);

    logic [1:0]                    r_state, n_state;
    logic [sned_pkg::NODES-1:0]    r_valid;
    logic [sned_pkg::NODE_AW-1:0]  r_addr;
    logic [4:0]                    r_node;
    sned_pkg::t_item               r_item;
    sned_pkg::t_cfg                r_cfg;
    sned_pkg::t_event [sned_pkg::MAX_EV-1:0] r_ev;
    logic [1:0]                    r_left;

    logic                          acc, in_range, ram_we;
    logic [sned_pkg::NODE_AW-1:0]  rd_addr;
    logic [ENT_W-1:0]              ram_rdata;
    sned_pkg::t_entry              ent_old, ent_new;
    sned_pkg::t_eval_res           res;
    logic signed [17:0]            cfg_deg;

    assign acc      = start && !busy;
    assign in_range = 32'(i_node_id) < 32'(sned_pkg::NODES);
    assign rd_addr  = sned_pkg::NODE_AW'(i_node_id);
    assign busy     = r_state != ST_IDLE;
    assign ram_we   = r_state == ST_EVAL;

    sned_ram #(
        .WIDTH (ENT_W),
        .DEPTH (sned_pkg::NODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ent_new),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // A never-written entry reads as cleared
    assign ent_old = r_valid[r_addr] ? sned_pkg::t_entry'(ram_rdata) : '0;

    sned_eval u_eval (
        .i_item (r_item),
        .i_ent  (ent_old),
        .i_cfg  (r_cfg),
        .o_res  (res),
        .o_ent  (ent_new)
    );

    assign cfg_deg = 18'(signed'(i_cfg_data[12:0])) * signed'(18'(sned_pkg::DEG_SCALE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_battery_pct   <= 7'd20;
            r_cfg.flat_wheel_level  <= 15'd1000;
            r_cfg.min_speed_kmh     <= 9'd15;
            r_cfg.red_lim           <= 18'd900;
            r_cfg.yel_lim           <= 18'd700;
            r_cfg.overload_level    <= 16'd110;
            r_cfg.load_step_min     <= 16'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sned_pkg::CFG_LOW_BATT:  r_cfg.low_battery_pct   <= i_cfg_data[6:0];
                sned_pkg::CFG_FLAT_LVL:  r_cfg.flat_wheel_level  <= i_cfg_data[14:0];
                sned_pkg::CFG_MIN_SPEED: r_cfg.min_speed_kmh     <= i_cfg_data[8:0];
                sned_pkg::CFG_BAND_RED:  r_cfg.red_lim           <= cfg_deg;
                sned_pkg::CFG_BAND_YEL:  r_cfg.yel_lim           <= cfg_deg;
                sned_pkg::CFG_OVERLOAD:  r_cfg.overload_level    <= i_cfg_data;
                sned_pkg::CFG_LOAD_DLT:  r_cfg.load_step_min     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && in_range) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = (res.count == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (r_left == 2'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_left  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == ST_EVAL) begin
                r_left <= res.count;
            end else if (r_state == ST_EMIT) begin
                r_left <= r_left - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_addr <= rd_addr;
            r_node <= i_node_id;
            r_item.kind            <= i_node_type;
            r_item.battery_pct     <= i_battery_pct;
            r_item.reading         <= i_reading;
            r_item.vibration_index <= i_vibration_index;
            r_item.door_open_flag  <= i_door_open_flag;
            r_item.alarm_flag      <= i_alarm_flag;
            r_item.impact_flag     <= i_impact_flag;
            r_item.speed           <= i_speed_kmh;
            r_item.moving          <= i_moving;
        end
        // Load the event slots, then advance one per cycle
        if (r_state == ST_EVAL) begin
            r_ev <= res.ev;
        end else if (r_state == ST_EMIT) begin
            r_ev <= {sned_pkg::t_event'('0), r_ev[sned_pkg::MAX_EV-1:1]};
        end
    end

    assign o_event_valid = r_state == ST_EMIT;
    assign o_event_code  = r_ev[0].code;
    assign o_edge_res    = r_ev[0].clr;
    assign o_event_node  = r_node;
    assign o_measured    = r_ev[0].measured;
    assign o_from_state  = r_ev[0].from_state;
    assign o_to_state    = r_ev[0].to_state;
    assign o_last        = r_left == 2'd1;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> busy)
        else $error("event strobe outside a busy report");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && o_last) |=> !o_event_valid)
        else $error("event after the last event of a report");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && acc))
        else $error("table write-back overlaps a new read");

    a_eval_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_range) |=> (r_state == ST_EVAL))
        else $error("accepted report not evaluated");

endmodule
